// ----- sv/rsls_pkg.sv -----
// Shared types and constants for the relative-step lamp sequencer.
// Used by the channel interfaces, the mapping unit, the divider and the top level.
// No dependencies.
package rsls_pkg;

    // Widths of the believed step values and of the millisecond counter
    localparam int STEP_BITS  = 8;
    localparam int DELAY_BITS = 16;

    localparam logic [STEP_BITS-1:0]  STEP_MAX  = {STEP_BITS{1'b1}};
    localparam logic [DELAY_BITS-1:0] DELAY_MAX = {DELAY_BITS{1'b1}};

    // Payload field widths
    localparam int FUNC_W   = 2;
    localparam int FRAC_W   = 11;
    localparam int FRAC_SH  = 10;
    localparam int MIRED_W  = 10;
    localparam int CMD_W    = 3;
    localparam int PCT_W    = 7;

    // Percent scale of the colour mapping
    localparam int PCT_SCALE = 100;

    // Divider geometry: dividend holds (warmest - mireds) * 100, divisor holds a mireds span
    localparam int DIV_NUM_W = 17;
    localparam int DIV_DEN_W = MIRED_W;
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

    // Request kinds
    localparam logic [FUNC_W-1:0] FUNC_SET      = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_TICK     = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CALIB    = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_OVERRIDE = 2'd3;

    // Step commands
    localparam logic [CMD_W-1:0] CMD_NONE   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_DIM_UP = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DIM_DN = 3'd2;
    localparam logic [CMD_W-1:0] CMD_COLDER = 3'd3;
    localparam logic [CMD_W-1:0] CMD_WARMER = 3'd4;

    // Transition modes
    localparam logic [1:0] MODE_IDLE   = 2'd0;
    localparam logic [1:0] MODE_TOGGLE = 2'd1;
    localparam logic [1:0] MODE_BRIGHT = 2'd2;
    localparam logic [1:0] MODE_COLOR  = 2'd3;

    // Register map (index = paddr / 4)
    localparam int REG_IDX_W = 3;
    localparam int PADDR_W   = REG_IDX_W + 2;
    localparam logic [REG_IDX_W-1:0] REG_BRIGHT_CNT = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_COLOR_CNT  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_COLDEST    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_WARMEST    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_DELAY      = 3'd4;

    localparam logic [7:0]            RST_BRIGHT_CNT = 8'd10;
    localparam logic [7:0]            RST_COLOR_CNT  = 8'd10;
    localparam logic [MIRED_W-1:0]    RST_COLDEST    = 10'd153;
    localparam logic [MIRED_W-1:0]    RST_WARMEST    = 10'd370;
    localparam logic [DELAY_BITS-1:0] RST_DELAY      = 16'd100;

    typedef logic [STEP_BITS-1:0]  t_step;
    typedef logic [DELAY_BITS-1:0] t_delay;

    // Mapping configuration handed to the mapping unit
    typedef struct packed {
        t_step              bright_cnt;
        t_step              color_cnt;
        logic [MIRED_W-1:0] coldest;
        logic [MIRED_W-1:0] warmest;
    } t_map_cfg;

    // Lamp sequencer state
    typedef struct packed {
        logic       first_sync;
        logic       power_now;
        logic       power_goal;
        logic       power_pending;
        t_step      bright_now;
        t_step      color_now;
        t_step      bright_goal;
        logic       bright_pending;
        t_step      color_goal;
        logic       color_pending;
        logic [1:0] mode;
        logic       step_up;
        t_step      steps_left;
        t_delay     since;
        logic       publish_due;
        logic       calib;
    } t_lamp;

    // Lamp state after reset: first sync due, everything else clear
    localparam t_lamp LAMP_RST = '{first_sync: 1'b1, default: '0};

    // One result item
    typedef struct packed {
        logic [CMD_W-1:0] step_cmd;
        logic             toggle_sent;
        logic             publish;
        logic             lamp_on;
        t_step            brightness_now;
        t_step            color_now;
        logic             busy_res;
        logic             calibrating;
    } t_res;

endpackage

// ----- sv/rsls_if.sv -----
// Valid/ready channel interfaces for lamp requests and lamp results.
// Depends on rsls_pkg.
interface rsls_in_if;
    logic                         valid;
    logic                         ready;
    logic [rsls_pkg::FUNC_W-1:0]  func;
    logic                         power_on;
    logic [rsls_pkg::FRAC_W-1:0]  brightness_frac;
    logic [rsls_pkg::MIRED_W-1:0] color_mireds;

    modport source (output valid, func, power_on, brightness_frac, color_mireds, input ready);
    modport sink   (input valid, func, power_on, brightness_frac, color_mireds, output ready);
endinterface

interface rsls_out_if;
    logic                       valid;
    logic                       ready;
    logic [rsls_pkg::CMD_W-1:0] step_cmd;
    logic                       toggle_sent;
    logic                       publish;
    logic                       lamp_on;
    rsls_pkg::t_step            brightness_now;
    rsls_pkg::t_step            color_now;
    logic                       busy_res;
    logic                       calibrating;

    modport source (output valid, step_cmd, toggle_sent, publish, lamp_on, brightness_now,
                    color_now, busy_res, calibrating, input ready);
    modport sink   (input valid, step_cmd, toggle_sent, publish, lamp_on, brightness_now,
                    color_now, busy_res, calibrating, output ready);
endinterface

// ----- sv/rsls_div.sv -----
// Restoring divider, one quotient bit per cycle, used for the colour percent division.
// Depends on rsls_pkg.
module rsls_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [rsls_pkg::DIV_NUM_W-1:0]  i_num,
    input  logic [rsls_pkg::DIV_DEN_W-1:0]  i_den,
    output logic                            o_done,
    output logic [rsls_pkg::DIV_NUM_W-1:0]  o_quo
);

    localparam logic [rsls_pkg::DIV_CNT_W-1:0] LAST = rsls_pkg::DIV_CNT_W'(rsls_pkg::DIV_NUM_W - 1);

    logic                             r_busy;
    logic                             r_done;
    logic [rsls_pkg::DIV_CNT_W-1:0]   r_cnt;
    logic [rsls_pkg::DIV_NUM_W-1:0]   r_quo;
    logic [rsls_pkg::DIV_DEN_W-1:0]   r_rem;
    logic [rsls_pkg::DIV_DEN_W-1:0]   r_den;
    logic [rsls_pkg::DIV_DEN_W:0]     rem_sh;
    logic                             fits;

    // Shift in the next dividend bit and try the subtract
    assign rem_sh = {r_rem, r_quo[rsls_pkg::DIV_NUM_W-1]};
    assign fits   = rem_sh >= {1'b0, r_den};

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= fits ? rsls_pkg::DIV_DEN_W'(rem_sh - {1'b0, r_den})
                          : rem_sh[rsls_pkg::DIV_DEN_W-1:0];
            r_quo <= {r_quo[rsls_pkg::DIV_NUM_W-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

    // Checks
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy) else $error("divider done while busy");

endmodule

// ----- sv/rsls_map.sv -----
// Maps a set request to brightness and colour step targets.
// Sequences the divider for the colour percent, then scales percent to steps by a
// reciprocal multiply. Depends on rsls_pkg and rsls_div.
module rsls_map (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [rsls_pkg::FRAC_W-1:0]   i_frac,
    input  logic [rsls_pkg::MIRED_W-1:0]  i_mireds,
    input  rsls_pkg::t_map_cfg            i_cfg,
    output logic                          o_done,
    output rsls_pkg::t_step               o_tb,
    output rsls_pkg::t_step               o_tc
);

    localparam logic [1:0] M_IDLE = 2'd0;
    localparam logic [1:0] M_PCT  = 2'd1;
    localparam logic [1:0] M_TC0  = 2'd2;
    localparam logic [1:0] M_TC   = 2'd3;

    localparam int BR_PROD_W = rsls_pkg::FRAC_W + rsls_pkg::STEP_BITS;

    // floor(x / 100) as (x * 10486) >> 20, exact for x up to 100 * 255
    localparam int                      TC_NUM_W     = rsls_pkg::PCT_W + rsls_pkg::STEP_BITS;
    localparam int                      PCT_RECIP_W  = 14;
    localparam int                      PCT_RECIP_SH = 20;
    localparam logic [PCT_RECIP_W-1:0]  PCT_RECIP    = 14'd10486;
    localparam int                      TC_PROD_W    = TC_NUM_W + PCT_RECIP_W;

    logic [1:0]                       r_mstate;
    logic [1:0]                       n_mstate;
    logic                             r_done;
    rsls_pkg::t_step                  r_tb;
    rsls_pkg::t_step                  r_tc;
    logic [rsls_pkg::PCT_W-1:0]       r_pct;
    logic [TC_NUM_W-1:0]              r_tcn;

    logic [BR_PROD_W-1:0]             br_prod;
    logic [BR_PROD_W-rsls_pkg::FRAC_SH-1:0] br_raw;
    rsls_pkg::t_step                  tb;
    logic                             at_warm;
    logic                             at_cold;
    logic [rsls_pkg::MIRED_W-1:0]     span_m;
    logic [rsls_pkg::DIV_NUM_W-1:0]   pct_num;
    logic [TC_NUM_W-1:0]              tc_num;
    logic [TC_PROD_W-1:0]             tc_prod;
    logic                             div_start;
    logic [rsls_pkg::DIV_DEN_W-1:0]   div_den;
    logic                             div_done;
    logic [rsls_pkg::DIV_NUM_W-1:0]   div_quo;

    // Brightness: frac * count / 1024, clamped to count
    assign br_prod = BR_PROD_W'(i_frac) * BR_PROD_W'(i_cfg.bright_cnt);
    assign br_raw  = br_prod[BR_PROD_W-1:rsls_pkg::FRAC_SH];
    assign tb      = (br_raw > (BR_PROD_W-rsls_pkg::FRAC_SH)'(i_cfg.bright_cnt))
                   ? i_cfg.bright_cnt : rsls_pkg::STEP_BITS'(br_raw);

    // Colour percent end cases come before any division
    assign at_warm = i_mireds >= i_cfg.warmest;
    assign at_cold = i_mireds <= i_cfg.coldest;
    assign span_m  = i_cfg.warmest - i_mireds;
    assign pct_num = rsls_pkg::DIV_NUM_W'(span_m) * rsls_pkg::DIV_NUM_W'(rsls_pkg::PCT_SCALE);

    // Percent to steps: one multiply per cycle
    assign tc_num  = TC_NUM_W'(r_pct) * TC_NUM_W'(i_cfg.color_cnt);
    assign tc_prod = TC_PROD_W'(r_tcn) * TC_PROD_W'(PCT_RECIP);

    // Divider operands
    assign div_start = (r_mstate == M_IDLE) && i_start && !at_warm && !at_cold;
    assign div_den   = rsls_pkg::DIV_DEN_W'(i_cfg.warmest - i_cfg.coldest);

    rsls_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (pct_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // Sequencer
    always_comb begin
        n_mstate = r_mstate;
        case (r_mstate)
            M_IDLE: begin
                if (i_start) begin
                    n_mstate = (at_warm || at_cold) ? M_TC0 : M_PCT;
                end
            end
            M_PCT: begin
                if (div_done) begin
                    n_mstate = M_TC0;
                end
            end
            M_TC0: n_mstate = M_TC;
            M_TC:  n_mstate = M_IDLE;
            default: n_mstate = M_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mstate <= M_IDLE;
            r_done   <= 1'b0;
        end else begin
            r_mstate <= n_mstate;
            r_done   <= (r_mstate == M_TC);
        end
    end

    // Results
    always_ff @(posedge i_clk) begin
        if (r_mstate == M_IDLE && i_start) begin
            r_tb  <= tb;
            r_pct <= at_warm ? '0 : rsls_pkg::PCT_W'(rsls_pkg::PCT_SCALE);
        end
        if (r_mstate == M_PCT && div_done) begin
            r_pct <= div_quo[rsls_pkg::PCT_W-1:0];
        end
        if (r_mstate == M_TC0) begin
            r_tcn <= tc_num;
        end
        if (r_mstate == M_TC) begin
            r_tc <= tc_prod[PCT_RECIP_SH +: rsls_pkg::STEP_BITS];
        end
    end

    assign o_done = r_done;
    assign o_tb   = r_tb;
    assign o_tc   = r_tc;

    // Checks
    a_pct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mstate == M_TC0) |-> (r_pct <= rsls_pkg::PCT_W'(rsls_pkg::PCT_SCALE)))
        else $error("colour percent out of range");

endmodule

// ----- sv/relative_step_lamp_sequencer_core.sv -----
// Top level of the relative-step lamp sequencer: request channel, result register,
// APB configuration registers and the lamp step/toggle state.
// Depends on rsls_pkg, rsls_if and rsls_map.
//
//  channel  | dir | handshake      | payload
//  ---------+-----+----------------+------------------------------------------------
//  i_in     | in  | valid / ready  | func, power_on, brightness_frac, color_mireds
//  o_out    | out | valid / ready  | step_cmd, toggle_sent, publish, lamp_on,
//           |     |                | brightness_now, color_now, busy_res, calibrating
//  apb      | in  | psel / penable | paddr, pwrite, pwdata, prdata, pready (always 1)
//
// A set request with a mid-range colour runs one divider pass, then percent-to-step
// scaling (M_TC0, M_TC) and the handoff to S_APPLY; at or past either end of the
// mireds range it skips the division. Tick, calibrate and override go straight to S_APPLY.
// One request is in flight at a time; the next is taken once its result is registered.
// A stalled result waits in the output register and blocks only the next update.
// Synchronous active-low reset; no clearing pass.
module relative_step_lamp_sequencer_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    rsls_in_if.sink                          i_in,
    rsls_out_if.source                       o_out,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [rsls_pkg::PADDR_W-1:0]     paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_MAP   = 2'd1;
    localparam logic [1:0] S_APPLY = 2'd2;

    logic [1:0]                      r_state;
    logic [1:0]                      n_state;
    logic [rsls_pkg::FUNC_W-1:0]     r_func;
    logic                            r_pw;
    rsls_pkg::t_lamp                 r_st;
    rsls_pkg::t_lamp                 n_st;
    logic                            r_out_valid;
    rsls_pkg::t_res                  r_out;
    rsls_pkg::t_res                  n_out;

    rsls_pkg::t_step                 r_bright_cnt;
    rsls_pkg::t_step                 r_color_cnt;
    logic [rsls_pkg::MIRED_W-1:0]    r_coldest;
    logic [rsls_pkg::MIRED_W-1:0]    r_warmest;
    rsls_pkg::t_delay                r_delay;

    rsls_pkg::t_map_cfg              map_cfg;
    logic                            map_done;
    rsls_pkg::t_step                 map_tb;
    rsls_pkg::t_step                 map_tc;
    logic                            accept;
    logic                            out_free;
    logic                            apply_fire;
    logic                            cfg_wr;
    logic [rsls_pkg::REG_IDX_W-1:0]  reg_idx;

    // Start the next transition from the pending goals, power first
    function automatic rsls_pkg::t_lamp lamp_advance(input rsls_pkg::t_lamp a);
        rsls_pkg::t_lamp b;
        b = a;
        if (b.power_pending) begin
            b.mode  = rsls_pkg::MODE_TOGGLE;
            b.since = '0;
        end else if (b.bright_pending && b.bright_goal != b.bright_now) begin
            b.step_up    = b.bright_goal > b.bright_now;
            b.steps_left = b.step_up ? b.bright_goal - b.bright_now
                                     : b.bright_now - b.bright_goal;
            b.mode       = rsls_pkg::MODE_BRIGHT;
            b.since      = rsls_pkg::DELAY_MAX;
        end else begin
            b.bright_pending = 1'b0;
            if (b.color_pending && b.color_goal != b.color_now) begin
                b.step_up    = b.color_goal > b.color_now;
                b.steps_left = b.step_up ? b.color_goal - b.color_now
                                         : b.color_now - b.color_goal;
                b.mode       = rsls_pkg::MODE_COLOR;
                b.since      = rsls_pkg::DELAY_MAX;
            end else begin
                b.color_pending = 1'b0;
                b.mode          = rsls_pkg::MODE_IDLE;
                b.calib         = 1'b0;
            end
        end
        return b;
    endfunction

    // One step in the walk direction, saturating at both ends
    function automatic rsls_pkg::t_step nudge(input rsls_pkg::t_step v, input logic up);
        if (up) begin
            return (v == rsls_pkg::STEP_MAX) ? v : v + 1'b1;
        end
        return (v == '0) ? v : v - 1'b1;
    endfunction

    // Handshakes
    assign accept     = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign out_free   = !r_out_valid || o_out.ready;
    assign apply_fire = (r_state == S_APPLY) && out_free;

    // Target mapping
    assign map_cfg = '{bright_cnt: r_bright_cnt, color_cnt: r_color_cnt,
                       coldest: r_coldest, warmest: r_warmest};

    rsls_map u_map (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (accept && i_in.func == rsls_pkg::FUNC_SET),
        .i_frac   (i_in.brightness_frac),
        .i_mireds (i_in.color_mireds),
        .i_cfg    (map_cfg),
        .o_done   (map_done),
        .o_tb     (map_tb),
        .o_tc     (map_tc)
    );

    // Request sequencing
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = (i_in.func == rsls_pkg::FUNC_SET) ? S_MAP : S_APPLY;
                end
            end
            S_MAP: begin
                if (map_done) begin
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Lamp state update for one request
    always_comb begin
        logic done;
        n_st  = r_st;
        n_out = '0;
        done  = 1'b0;
        case (r_func)
            rsls_pkg::FUNC_SET: begin
                if (r_st.first_sync) begin
                    n_st.first_sync = 1'b0;
                    n_st.power_now  = r_pw;
                    n_st.bright_now = map_tb;
                    n_st.color_now  = map_tc;
                end else begin
                    if (r_pw != r_st.power_now) begin
                        n_st.power_goal    = r_pw;
                        n_st.power_pending = 1'b1;
                    end
                    if (r_pw) begin
                        if (map_tb != r_st.bright_now) begin
                            n_st.bright_goal    = map_tb;
                            n_st.bright_pending = 1'b1;
                        end
                        if (map_tc != r_st.color_now) begin
                            n_st.color_goal    = map_tc;
                            n_st.color_pending = 1'b1;
                        end
                    end
                    if (r_st.mode == rsls_pkg::MODE_IDLE) begin
                        n_st = lamp_advance(n_st);
                        n_out.toggle_sent = (n_st.mode == rsls_pkg::MODE_TOGGLE);
                    end
                end
            end
            rsls_pkg::FUNC_TICK: begin
                n_out.publish    = r_st.publish_due;
                n_st.publish_due = 1'b0;
                if (r_st.since != rsls_pkg::DELAY_MAX) begin
                    n_st.since = r_st.since + 1'b1;
                end
                if (r_st.mode != rsls_pkg::MODE_IDLE &&
                    (n_st.since >= r_delay || n_st.since == rsls_pkg::DELAY_MAX)) begin
                    n_st.since = '0;
                    if (r_st.mode == rsls_pkg::MODE_TOGGLE) begin
                        n_st.power_now     = r_st.power_goal;
                        n_st.power_pending = 1'b0;
                        done               = 1'b1;
                    end else begin
                        if (r_st.steps_left != '0) begin
                            if (r_st.mode == rsls_pkg::MODE_BRIGHT) begin
                                n_out.step_cmd  = r_st.step_up ? rsls_pkg::CMD_DIM_UP
                                                               : rsls_pkg::CMD_DIM_DN;
                                n_st.bright_now = nudge(r_st.bright_now, r_st.step_up);
                            end else begin
                                n_out.step_cmd  = r_st.step_up ? rsls_pkg::CMD_COLDER
                                                               : rsls_pkg::CMD_WARMER;
                                n_st.color_now  = nudge(r_st.color_now, r_st.step_up);
                            end
                            n_st.steps_left = r_st.steps_left - 1'b1;
                        end
                        done = (n_st.steps_left == '0);
                    end
                    if (done) begin
                        n_st.mode = rsls_pkg::MODE_IDLE;
                        n_st      = lamp_advance(n_st);
                        n_out.toggle_sent = (n_st.mode == rsls_pkg::MODE_TOGGLE);
                        if (n_st.mode == rsls_pkg::MODE_IDLE) begin
                            n_st.publish_due = 1'b1;
                        end
                    end
                end
            end
            rsls_pkg::FUNC_CALIB: begin
                if (!r_st.calib) begin
                    n_st.calib          = 1'b1;
                    n_st.bright_now     = r_bright_cnt;
                    n_st.color_now      = '0;
                    n_st.power_now      = 1'b1;
                    n_st.bright_goal    = '0;
                    n_st.color_goal     = r_color_cnt;
                    n_st.bright_pending = 1'b1;
                    n_st.color_pending  = 1'b1;
                    if (r_st.mode == rsls_pkg::MODE_IDLE) begin
                        n_st = lamp_advance(n_st);
                        n_out.toggle_sent = (n_st.mode == rsls_pkg::MODE_TOGGLE);
                    end
                end
            end
            rsls_pkg::FUNC_OVERRIDE: begin
                n_st.power_now   = r_pw;
                n_st.publish_due = 1'b1;
            end
            default: n_st = r_st;
        endcase
        n_out.lamp_on        = n_st.power_now;
        n_out.brightness_now = n_st.bright_now;
        n_out.color_now      = n_st.color_now;
        n_out.busy_res       = (n_st.mode != rsls_pkg::MODE_IDLE);
        n_out.calibrating    = n_st.calib;
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_st        <= rsls_pkg::LAMP_RST;
        end else begin
            r_state <= n_state;
            if (apply_fire) begin
                r_st        <= n_st;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func <= i_in.func;
            r_pw   <= i_in.power_on;
        end
        if (apply_fire) begin
            r_out <= n_out;
        end
    end

    // Configuration registers
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[rsls_pkg::PADDR_W-1:2];
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bright_cnt <= rsls_pkg::RST_BRIGHT_CNT;
            r_color_cnt  <= rsls_pkg::RST_COLOR_CNT;
            r_coldest    <= rsls_pkg::RST_COLDEST;
            r_warmest    <= rsls_pkg::RST_WARMEST;
            r_delay      <= rsls_pkg::RST_DELAY;
        end else if (cfg_wr) begin
            case (reg_idx)
                rsls_pkg::REG_BRIGHT_CNT: r_bright_cnt <= pwdata[rsls_pkg::STEP_BITS-1:0];
                rsls_pkg::REG_COLOR_CNT:  r_color_cnt  <= pwdata[rsls_pkg::STEP_BITS-1:0];
                rsls_pkg::REG_COLDEST:    r_coldest    <= pwdata[rsls_pkg::MIRED_W-1:0];
                rsls_pkg::REG_WARMEST:    r_warmest    <= pwdata[rsls_pkg::MIRED_W-1:0];
                rsls_pkg::REG_DELAY:      r_delay      <= pwdata[rsls_pkg::DELAY_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Register readback
    always_comb begin
        case (reg_idx)
            rsls_pkg::REG_BRIGHT_CNT: prdata = 32'(r_bright_cnt);
            rsls_pkg::REG_COLOR_CNT:  prdata = 32'(r_color_cnt);
            rsls_pkg::REG_COLDEST:    prdata = 32'(r_coldest);
            rsls_pkg::REG_WARMEST:    prdata = 32'(r_warmest);
            rsls_pkg::REG_DELAY:      prdata = 32'(r_delay);
            default:                  prdata = '0;
        endcase
    end

    // Result channel
    assign o_out.valid          = r_out_valid;
    assign o_out.step_cmd       = r_out.step_cmd;
    assign o_out.toggle_sent    = r_out.toggle_sent;
    assign o_out.publish        = r_out.publish;
    assign o_out.lamp_on        = r_out.lamp_on;
    assign o_out.brightness_now = r_out.brightness_now;
    assign o_out.color_now      = r_out.color_now;
    assign o_out.busy_res       = r_out.busy_res;
    assign o_out.calibrating    = r_out.calibrating;

    // Checks
    a_map_done_in_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        map_done |-> (r_state == S_MAP)) else $error("mapping finished outside map state");

    a_walk_has_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st.mode == rsls_pkg::MODE_BRIGHT || r_st.mode == rsls_pkg::MODE_COLOR)
        |-> (r_st.steps_left != '0)) else $error("step walk with no steps left");

    a_apply_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        apply_fire |=> (r_out_valid && r_state == S_IDLE))
        else $error("result not registered after update");

    a_toggle_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        apply_fire && n_out.toggle_sent |-> (n_st.mode == rsls_pkg::MODE_TOGGLE))
        else $error("toggle sent without toggle mode");

endmodule
